// ===== src/oaht_pkg.sv =====
package oaht_pkg;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [2:0] ST_FOUND     = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_INSERTED  = 3'd2;
    localparam logic [2:0] ST_UPDATED   = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    localparam logic [31:0] TAG_UNUSED = 32'd0;
    localparam logic [31:0] TAG_TOMB   = 32'd1;
    localparam logic [31:0] HASH_MIN   = 32'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] key_word;
        logic [31:0] hash_word;
        logic [31:0] value_in;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] key_out;
        logic [31:0] value_out;
        logic [7:0]  slot_index;
        logic [8:0]  entry_count;
    } t_rsp;

    typedef struct packed {
        logic [31:0] tag;
        logic [31:0] key_word;
        logic [31:0] value;
    } t_slot;

endpackage

// ===== src/oaht_mod.sv =====
module oaht_mod #(
    parameter int PROBE_MODULUS = 251,
    parameter int IDX_W         = 8
) (
    input  logic             i_clk,
    input  logic [31:0]      i_hash,
    output logic [IDX_W-1:0] o_start
);

    localparam int          SHIFT = 32 + $clog2(PROBE_MODULUS);
    localparam logic [63:0] RECIP = (64'd1 << SHIFT) / PROBE_MODULUS;
    localparam logic [32:0] RECIP_C = RECIP[32:0];
    localparam logic [31:0] MOD_C = 32'(PROBE_MODULUS);

    logic [64:0] w_prod;
    logic [31:0] r_q;
    logic [31:0] r_qp;
    logic [31:0] w_rem;
    logic [31:0] w_mod;

    // quotient estimate is exact or one low
    assign w_prod = 65'(i_hash) * 65'(RECIP_C);

    always_ff @(posedge i_clk) begin
        r_q  <= 32'(w_prod >> SHIFT);
        r_qp <= r_q * MOD_C;
    end

    assign w_rem   = i_hash - r_qp;
    assign w_mod   = (w_rem >= MOD_C) ? (w_rem - MOD_C) : w_rem;
    assign o_start = w_mod[IDX_W-1:0];

endmodule

// ===== src/open_addressing_hash_table.sv =====
// a request passes the hash-mod arithmetic (S_MOD1, S_MOD2, S_START), then one memory read
// per probed slot (1 to TABLE_SIZE slots probed), then at most one write-back (insert or remove)
// a new request is taken only in S_IDLE, once the previous response has been issued
// clear request: one slot tag wiped per cycle, then a response
// reset: synchronous; a sweep wipes all tags, no request taken meanwhile
module open_addressing_hash_table #(
    parameter int TABLE_SIZE    = 256,
    parameter int PROBE_MODULUS = 251
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  oaht_pkg::t_req i_req,
    output logic           o_rsp_valid,
    input  logic           i_rsp_ready,
    output oaht_pkg::t_rsp o_rsp
);

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int CNT_W = IDX_W + 1;

    typedef enum logic [2:0] {
        S_IDLE, S_CLEAR, S_MOD1, S_MOD2, S_START, S_PROBE, S_DONE
    } t_state;

    t_state               r_state;
    oaht_pkg::t_req       r_req;
    logic [31:0]          r_hash;
    logic [CNT_W-1:0]     r_count;
    logic [IDX_W-1:0]     r_clr_idx;
    logic                 r_clr_req;
    logic [IDX_W-1:0]     r_next_idx;
    logic [IDX_W-1:0]     r_step;
    logic [IDX_W-1:0]     r_seen;
    logic                 r_have_tomb;
    logic [IDX_W-1:0]     r_tomb_idx;
    logic                 r_matched;
    logic                 r_have_free;
    logic [IDX_W-1:0]     r_res_idx;
    oaht_pkg::t_slot      r_ent;
    logic                 r_rsp_valid;
    oaht_pkg::t_rsp       r_rsp;

    oaht_pkg::t_slot      mem [TABLE_SIZE];
    oaht_pkg::t_slot      r_rd_data;
    logic [IDX_W-1:0]     r_rd_idx;

    logic [IDX_W-1:0]     w_start;
    logic [IDX_W-1:0]     w_rd_addr;
    logic                 w_we;
    logic [IDX_W-1:0]     w_wr_addr;
    oaht_pkg::t_slot      w_wr_data;
    logic                 w_tag_unused;
    logic                 w_tag_match;
    logic                 w_tag_tomb;
    logic                 w_stop;
    logic                 w_free_ok;
    logic [IDX_W-1:0]     w_free_idx;
    logic                 w_done_go;
    oaht_pkg::t_rsp       n_rsp;
    logic [CNT_W-1:0]     n_count;
    logic [31:0]          w_hash_adj;

    oaht_mod #(
        .PROBE_MODULUS (PROBE_MODULUS),
        .IDX_W         (IDX_W)
    ) u_mod (
        .i_clk   (i_clk),
        .i_hash  (r_hash),
        .o_start (w_start)
    );

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    assign w_hash_adj = (i_req.hash_word < oaht_pkg::HASH_MIN) ? oaht_pkg::HASH_MIN
                                                                : i_req.hash_word;

    // probe evaluation of the slot read last cycle
    assign w_tag_unused = (r_rd_data.tag == oaht_pkg::TAG_UNUSED);
    assign w_tag_tomb   = (r_rd_data.tag == oaht_pkg::TAG_TOMB);
    assign w_tag_match  = (r_rd_data.tag == r_hash) && (r_rd_data.key_word == r_req.key_word);
    assign w_stop       = w_tag_unused || w_tag_match || (&r_seen);
    assign w_free_ok    = r_have_tomb || w_tag_unused || w_tag_tomb;
    assign w_free_idx   = r_have_tomb ? r_tomb_idx : r_rd_idx;

    assign w_done_go = (r_state == S_DONE) && (!r_rsp_valid || i_rsp_ready);
    assign w_rd_addr = (r_state == S_START) ? w_start : r_next_idx;

    always_comb begin
        n_rsp       = '0;
        n_rsp.status = oaht_pkg::ST_NOT_FOUND;
        n_count     = r_count;
        w_we        = 1'b0;
        w_wr_addr   = r_res_idx;
        w_wr_data   = r_ent;
        if (r_state == S_CLEAR) begin
            w_we      = 1'b1;
            w_wr_addr = r_clr_idx;
            w_wr_data = '0;
        end else begin
            unique case (r_req.op)
                oaht_pkg::OP_CLEAR: begin
                    n_rsp.status = oaht_pkg::ST_FOUND;
                end
                oaht_pkg::OP_LOOKUP: begin
                    if (r_matched) begin
                        n_rsp.status     = oaht_pkg::ST_FOUND;
                        n_rsp.key_out    = r_ent.key_word;
                        n_rsp.value_out  = r_ent.value;
                        n_rsp.slot_index = 8'(r_res_idx);
                    end
                end
                oaht_pkg::OP_REMOVE: begin
                    if (r_matched) begin
                        n_rsp.status     = oaht_pkg::ST_FOUND;
                        n_rsp.key_out    = r_ent.key_word;
                        n_rsp.value_out  = r_ent.value;
                        n_rsp.slot_index = 8'(r_res_idx);
                        w_we             = w_done_go;
                        w_wr_data        = '{oaht_pkg::TAG_TOMB, 32'd0, 32'd0};
                        if (r_count != '0) begin
                            n_count = r_count - CNT_W'(1);
                        end
                    end
                end
                oaht_pkg::OP_INSERT: begin
                    if (r_matched) begin
                        n_rsp.status     = oaht_pkg::ST_UPDATED;
                        n_rsp.key_out    = r_ent.key_word;
                        n_rsp.value_out  = r_ent.value;
                        n_rsp.slot_index = 8'(r_res_idx);
                        w_we             = w_done_go;
                        w_wr_data        = '{r_ent.tag, r_ent.key_word, r_req.value_in};
                    end else if (r_have_free) begin
                        n_rsp.status     = oaht_pkg::ST_INSERTED;
                        n_rsp.slot_index = 8'(r_res_idx);
                        w_we             = w_done_go;
                        w_wr_data        = '{r_hash, r_req.key_word, r_req.value_in};
                        n_count          = r_count + CNT_W'(1);
                    end else begin
                        n_rsp.status = oaht_pkg::ST_FULL;
                    end
                end
                default: begin
                    n_rsp.status = oaht_pkg::ST_NOT_FOUND;
                end
            endcase
        end
        n_rsp.entry_count = 9'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= mem[w_rd_addr];
        r_rd_idx  <= w_rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_clr_req   <= 1'b0;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
            r_have_tomb <= 1'b0;
        end else begin
            if (r_rsp_valid && i_rsp_ready && !w_done_go) begin
                r_rsp_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_req  <= i_req;
                        r_hash <= w_hash_adj;
                        if (i_req.op == oaht_pkg::OP_CLEAR) begin
                            r_state   <= S_CLEAR;
                            r_clr_idx <= '0;
                            r_clr_req <= 1'b1;
                            r_count   <= '0;
                        end else begin
                            r_state <= S_MOD1;
                        end
                    end
                end
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + IDX_W'(1);
                    if (&r_clr_idx) begin
                        r_state <= r_clr_req ? S_DONE : S_IDLE;
                    end
                end
                S_MOD1: begin
                    r_state <= S_MOD2;
                end
                S_MOD2: begin
                    r_state <= S_START;
                end
                S_START: begin
                    r_next_idx  <= w_start + IDX_W'(1);
                    r_step      <= IDX_W'(2);
                    r_seen      <= '0;
                    r_have_tomb <= 1'b0;
                    r_state     <= S_PROBE;
                end
                S_PROBE: begin
                    r_next_idx <= r_next_idx + r_step;
                    r_step     <= r_step + IDX_W'(1);
                    r_seen     <= r_seen + IDX_W'(1);
                    if (w_tag_tomb && !r_have_tomb) begin
                        r_have_tomb <= 1'b1;
                        r_tomb_idx  <= r_rd_idx;
                    end
                    if (w_stop) begin
                        r_matched   <= w_tag_match;
                        r_have_free <= w_free_ok;
                        r_res_idx   <= w_tag_match ? r_rd_idx : w_free_idx;
                        r_ent       <= r_rd_data;
                        r_state     <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_done_go) begin
                        r_rsp       <= n_rsp;
                        r_rsp_valid <= 1'b1;
                        r_count     <= n_count;
                        r_clr_req   <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_clear_sweeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready && i_req.op == oaht_pkg::OP_CLEAR)
        |=> (r_state == S_CLEAR && r_count == '0))
        else $error("clear request did not start the tag sweep");

    a_insert_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done_go && n_rsp.status == oaht_pkg::ST_INSERTED)
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("new entry did not raise the live count");

    a_write_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_CLEAR || w_done_go))
        else $error("table write outside sweep or completion");

    a_match_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_matched) |-> (r_ent.tag >= oaht_pkg::HASH_MIN))
        else $error("matched slot does not hold a live tag");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done_go && n_rsp.status == oaht_pkg::ST_FULL)
        |-> (r_count != '0))
        else $error("table reported full with no live entries");

endmodule
